/* rtl/core/ftsw_pkg.sv */
package ftsw_pkg;

   localparam int COLOR_BITS = 32;

   // request operations
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_SPAN = 1'b1;

   // load sequencer
   typedef enum logic [6:0] {
      SQ_READY = 7'b0000001,
      SQ_MUL   = 7'b0000010,
      SQ_SPLIT = 7'b0000100,
      SQ_BS    = 7'b0001000,
      SQ_BE    = 7'b0010000,
      SQ_TS    = 7'b0100000,
      SQ_TE    = 7'b1000000
   } seq_type;

   // walk phase of the active triangle
   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_BOTTOM = 3'b010,
      PH_TOP    = 3'b100
   } phase_type;

endpackage

/* rtl/core/ftsw_div.sv */
module ftsw_div #(
   parameter int NUM_BITS = 28,
   parameter int DEN_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);

   localparam int CW = $clog2(NUM_BITS + 1);

   logic                busy_ff;
   logic                done_ff;
   logic [CW-1:0]       cnt_ff;
   logic [DEN_BITS-1:0] rem_ff;
   logic [DEN_BITS-1:0] den_ff;
   logic [NUM_BITS-1:0] quo_ff;

   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   // restoring step: one quotient bit per cycle, dividend bits shift out of quo_ff
   assign trial = {rem_ff, quo_ff[NUM_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quo_ff <= {quo_ff[NUM_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/ftsw_span.sv */
module ftsw_span #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                     phase_top,
   input  logic signed [COORD_BITS+FRAC_BITS+1:0]   acc_start,
   input  logic signed [COORD_BITS+FRAC_BITS+1:0]   acc_end,
   input  logic signed [COORD_BITS+FRAC_BITS+1:0]   slope_start,
   input  logic signed [COORD_BITS+FRAC_BITS+1:0]   slope_end,
   output logic signed [COORD_BITS:0]               span_left,
   output logic signed [COORD_BITS:0]               span_right,
   output logic signed [COORD_BITS+FRAC_BITS+1:0]   next_start,
   output logic signed [COORD_BITS+FRAC_BITS+1:0]   next_end
);

   localparam int AW = COORD_BITS + FRAC_BITS + 2;
   localparam int C1 = COORD_BITS + 1;

   logic signed [C1-1:0] x_start;
   logic signed [C1-1:0] x_end;

   // fixed point to integer, truncated toward zero
   function automatic logic signed [C1-1:0] trunc_x(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] sh;
      sh = a >>> FRAC_BITS;
      if (a[AW-1] && (a[FRAC_BITS-1:0] != '0)) begin
         sh = sh + AW'(1);
      end
      return sh[C1-1:0];
   endfunction

   assign x_start = trunc_x(acc_start);
   assign x_end   = trunc_x(acc_end);

   always_comb begin
      if (x_end < x_start) begin
         span_left  = x_end;
         span_right = x_start;
      end else begin
         span_left  = x_start;
         span_right = x_end;
      end
   end

   // flat-top part walks upward, so the edges step back
   assign next_start = phase_top ? acc_start - slope_start : acc_start + slope_start;
   assign next_end   = phase_top ? acc_end - slope_end : acc_end + slope_end;

endmodule

/* rtl/core/flat_triangle_span_walker.sv */
// Flat-shaded triangle span walker. A load item (op 0) sorts the three vertices by y,
// splits the triangle at the middle vertex, sets both edge slopes of each part; a shared
// bit-serial divider does the split and the slopes in turn, so a load keeps req_ready
// low until the last slope is done. Loads give no result. After that each next-span
// item (op 1) yields one span, so spans stream at one per cycle while rsp_ready stays
// high. The flat-bottom part is walked downward from the top vertex, then the flat-top
// part upward from the bottom vertex, so the middle row comes out twice. A request with
// no active triangle returns an item with span_valid low and all other fields zero.
module flat_triangle_span_walker #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic signed [COORD_BITS-1:0]         req_ax,
   input  logic signed [COORD_BITS-1:0]         req_ay,
   input  logic signed [COORD_BITS-1:0]         req_bx,
   input  logic signed [COORD_BITS-1:0]         req_by_coord,
   input  logic signed [COORD_BITS-1:0]         req_cx,
   input  logic signed [COORD_BITS-1:0]         req_cy,
   input  logic [ftsw_pkg::COLOR_BITS-1:0]      req_fill_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [COORD_BITS-1:0]         rsp_span_row,
   output logic signed [COORD_BITS:0]           rsp_span_left,
   output logic signed [COORD_BITS:0]           rsp_span_right,
   output logic [ftsw_pkg::COLOR_BITS-1:0]      rsp_span_color,
   output logic                                 rsp_span_valid,
   output logic                                 rsp_span_last
);

   import ftsw_pkg::*;

   localparam int C   = COORD_BITS;
   localparam int C1  = COORD_BITS + 1;
   localparam int AW  = COORD_BITS + FRAC_BITS + 2;
   localparam int NW  = (COORD_BITS + FRAC_BITS > 2 * COORD_BITS) ?
                        COORD_BITS + FRAC_BITS : 2 * COORD_BITS;
   localparam int NWP = NW + 1;
   localparam int QW  = (AW > NWP) ? AW : NWP;

   seq_type   seq_ff;
   phase_type phase_ff;
   logic      start_ff;

   logic signed [C-1:0]      vx_ff [3];
   logic signed [C-1:0]      vy_ff [3];
   logic signed [C1-1:0]     split_x_ff;
   logic signed [C-1:0]      row_ff;
   logic signed [AW-1:0]     acc_s_ff;
   logic signed [AW-1:0]     acc_e_ff;
   logic signed [AW-1:0]     slope_s_ff;
   logic signed [AW-1:0]     slope_e_ff;
   logic signed [AW-1:0]     bot_s_ff;
   logic signed [AW-1:0]     bot_e_ff;
   logic signed [AW-1:0]     top_s_ff;
   logic signed [AW-1:0]     top_e_ff;
   logic signed [2*C1-1:0]   prod_ff;
   logic [COLOR_BITS-1:0]    color_ff;

   logic                     rsp_valid_ff;
   logic signed [C-1:0]      rsp_row_ff;
   logic signed [C1-1:0]     rsp_left_ff;
   logic signed [C1-1:0]     rsp_right_ff;
   logic [COLOR_BITS-1:0]    rsp_color_ff;
   logic                     rsp_span_valid_ff;
   logic                     rsp_last_ff;

   logic signed [C-1:0]      lx [3];
   logic signed [C-1:0]      ly [3];

   logic signed [C1-1:0]     dx01, dx02, dx12, dxs0, dx2s;
   logic signed [C1-1:0]     dy01, dy02, dy12;
   logic signed [NWP-1:0]    num_sel;
   logic [C-1:0]             den_sel;
   logic                     num_neg;
   logic [NW-1:0]            num_mag;
   logic                     div_done;
   logic [NW-1:0]            div_quo;
   logic signed [QW-1:0]     q_s;
   logic signed [AW-1:0]     slope_res;
   logic signed [C1-1:0]     split_res;

   logic signed [C1-1:0]     span_left;
   logic signed [C1-1:0]     span_right;
   logic signed [AW-1:0]     next_s;
   logic signed [AW-1:0]     next_e;

   logic                     req_take;

   assign req_ready = (seq_ff == SQ_READY) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;

   // three compare-swaps, stable among equal y
   always_comb begin
      lx[0] = req_ax;
      lx[1] = req_bx;
      lx[2] = req_cx;
      ly[0] = req_ay;
      ly[1] = req_by_coord;
      ly[2] = req_cy;
      if (ly[0] > ly[1]) begin
         {lx[0], lx[1]} = {lx[1], lx[0]};
         {ly[0], ly[1]} = {ly[1], ly[0]};
      end
      if (ly[1] > ly[2]) begin
         {lx[1], lx[2]} = {lx[2], lx[1]};
         {ly[1], ly[2]} = {ly[2], ly[1]};
      end
      if (ly[0] > ly[1]) begin
         {lx[0], lx[1]} = {lx[1], lx[0]};
         {ly[0], ly[1]} = {ly[1], ly[0]};
      end
   end

   assign dx01 = C1'(vx_ff[1]) - C1'(vx_ff[0]);
   assign dx02 = C1'(vx_ff[2]) - C1'(vx_ff[0]);
   assign dx12 = C1'(vx_ff[2]) - C1'(vx_ff[1]);
   assign dxs0 = split_x_ff - C1'(vx_ff[0]);
   assign dx2s = C1'(vx_ff[2]) - split_x_ff;
   assign dy01 = C1'(vy_ff[1]) - C1'(vy_ff[0]);
   assign dy02 = C1'(vy_ff[2]) - C1'(vy_ff[0]);
   assign dy12 = C1'(vy_ff[2]) - C1'(vy_ff[1]);

   // divider operands follow the sequencer state and hold through a division
   always_comb begin
      unique case (seq_ff)
         SQ_SPLIT: begin
            num_sel = NWP'(prod_ff);
            den_sel = dy02[C-1:0];
         end
         SQ_BS: begin
            num_sel = (NWP'(dx01)) <<< FRAC_BITS;
            den_sel = dy01[C-1:0];
         end
         SQ_BE: begin
            num_sel = (NWP'(dxs0)) <<< FRAC_BITS;
            den_sel = dy01[C-1:0];
         end
         SQ_TS: begin
            num_sel = (NWP'(dx12)) <<< FRAC_BITS;
            den_sel = dy12[C-1:0];
         end
         SQ_TE: begin
            num_sel = (NWP'(dx2s)) <<< FRAC_BITS;
            den_sel = dy12[C-1:0];
         end
         default: begin
            num_sel = '0;
            den_sel = '0;
         end
      endcase
   end

   assign num_neg = num_sel[NWP-1];
   assign num_mag = num_neg ? NW'(-num_sel) : NW'(num_sel);

   ftsw_div #(
      .NUM_BITS(NW),
      .DEN_BITS(C)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (num_mag),
      .divisor  (den_sel),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign q_s       = num_neg ? QW'(0) - QW'(div_quo) : QW'(div_quo);
   assign slope_res = (den_sel == '0) ? '0 : q_s[AW-1:0];
   assign split_res = (vy_ff[2] == vy_ff[0]) ? C1'(vx_ff[2]) : C1'(vx_ff[0]) + q_s[C1-1:0];

   ftsw_span #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_span (
      .phase_top   (phase_ff == PH_TOP),
      .acc_start   (acc_s_ff),
      .acc_end     (acc_e_ff),
      .slope_start (slope_s_ff),
      .slope_end   (slope_e_ff),
      .span_left   (span_left),
      .span_right  (span_right),
      .next_start  (next_s),
      .next_end    (next_e)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SQ_READY;
         phase_ff     <= PH_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // next division starts right after the product or a finished quotient other than the last
         start_ff <= (seq_ff == SQ_MUL) || (div_done && seq_ff != SQ_TE);
         if (req_take && req_op == OP_SPAN) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (seq_ff)
            SQ_READY: begin
               if (req_take && req_op == OP_LOAD) begin
                  seq_ff <= SQ_MUL;
               end else if (req_take) begin
                  unique case (phase_ff)
                     PH_BOTTOM: begin
                        if (row_ff >= vy_ff[1]) begin
                           phase_ff <= (vy_ff[1] == vy_ff[2]) ? PH_IDLE : PH_TOP;
                        end
                     end
                     PH_TOP: begin
                        if (row_ff <= vy_ff[1]) begin
                           phase_ff <= PH_IDLE;
                        end
                     end
                     default: begin
                        phase_ff <= PH_IDLE;
                     end
                  endcase
               end
            end
            SQ_MUL: begin
               seq_ff <= SQ_SPLIT;
            end
            SQ_SPLIT, SQ_BS, SQ_BE, SQ_TS: begin
               if (div_done) begin
                  unique case (seq_ff)
                     SQ_SPLIT: seq_ff <= SQ_BS;
                     SQ_BS:    seq_ff <= SQ_BE;
                     SQ_BE:    seq_ff <= SQ_TS;
                     default:  seq_ff <= SQ_TE;
                  endcase
               end
            end
            SQ_TE: begin
               if (div_done) begin
                  seq_ff   <= SQ_READY;
                  phase_ff <= (vy_ff[0] == vy_ff[1] && vy_ff[1] != vy_ff[2]) ?
                              PH_TOP : PH_BOTTOM;
               end
            end
            default: begin
               seq_ff <= SQ_READY;
            end
         endcase
      end
   end

   // triangle and walk data
   always_ff @(posedge clock) begin
      if (seq_ff == SQ_READY && req_take && req_op == OP_LOAD) begin
         vx_ff[0] <= lx[0];
         vx_ff[1] <= lx[1];
         vx_ff[2] <= lx[2];
         vy_ff[0] <= ly[0];
         vy_ff[1] <= ly[1];
         vy_ff[2] <= ly[2];
         color_ff <= req_fill_color;
      end
      if (seq_ff == SQ_MUL) begin
         prod_ff <= (2*C1)'(dx02) * (2*C1)'(dy01);
      end
      if (div_done) begin
         unique case (seq_ff)
            SQ_SPLIT: split_x_ff <= split_res;
            SQ_BS:    bot_s_ff   <= slope_res;
            SQ_BE:    bot_e_ff   <= slope_res;
            SQ_TS:    top_s_ff   <= slope_res;
            SQ_TE:    top_e_ff   <= slope_res;
            default: ;
         endcase
      end
      if (seq_ff == SQ_TE && div_done) begin
         if (vy_ff[0] == vy_ff[1] && vy_ff[1] != vy_ff[2]) begin
            row_ff     <= vy_ff[2];
            acc_s_ff   <= (AW'(vx_ff[2])) <<< FRAC_BITS;
            acc_e_ff   <= (AW'(vx_ff[2])) <<< FRAC_BITS;
            slope_s_ff <= top_s_ff;
            slope_e_ff <= slope_res;
         end else begin
            row_ff     <= vy_ff[0];
            acc_s_ff   <= (AW'(vx_ff[0])) <<< FRAC_BITS;
            acc_e_ff   <= (AW'(vx_ff[0])) <<< FRAC_BITS;
            slope_s_ff <= bot_s_ff;
            slope_e_ff <= bot_e_ff;
         end
      end
      if (seq_ff == SQ_READY && req_take && req_op == OP_SPAN) begin
         if (phase_ff == PH_BOTTOM && row_ff >= vy_ff[1]) begin
            // switch over to the flat-top part at the bottom vertex
            row_ff     <= vy_ff[2];
            acc_s_ff   <= (AW'(vx_ff[2])) <<< FRAC_BITS;
            acc_e_ff   <= (AW'(vx_ff[2])) <<< FRAC_BITS;
            slope_s_ff <= top_s_ff;
            slope_e_ff <= top_e_ff;
         end else if (phase_ff == PH_BOTTOM) begin
            row_ff   <= row_ff + C'(1);
            acc_s_ff <= next_s;
            acc_e_ff <= next_e;
         end else if (phase_ff == PH_TOP && row_ff > vy_ff[1]) begin
            row_ff   <= row_ff - C'(1);
            acc_s_ff <= next_s;
            acc_e_ff <= next_e;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (seq_ff == SQ_READY && req_take && req_op == OP_SPAN) begin
         if (phase_ff == PH_BOTTOM || phase_ff == PH_TOP) begin
            rsp_row_ff        <= row_ff;
            rsp_left_ff       <= span_left;
            rsp_right_ff      <= span_right;
            rsp_color_ff      <= color_ff;
            rsp_span_valid_ff <= 1'b1;
            rsp_last_ff       <= (phase_ff == PH_BOTTOM) ?
                                 (row_ff >= vy_ff[1] && vy_ff[1] == vy_ff[2]) :
                                 (row_ff <= vy_ff[1]);
         end else begin
            rsp_row_ff        <= '0;
            rsp_left_ff       <= '0;
            rsp_right_ff      <= '0;
            rsp_color_ff      <= '0;
            rsp_span_valid_ff <= 1'b0;
            rsp_last_ff       <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_row   = rsp_row_ff;
   assign rsp_span_left  = rsp_left_ff;
   assign rsp_span_right = rsp_right_ff;
   assign rsp_span_color = rsp_color_ff;
   assign rsp_span_valid = rsp_span_valid_ff;
   assign rsp_span_last  = rsp_last_ff;

endmodule

/* tb/tb_flat_triangle_span_walker.sv */
module tb_flat_triangle_span_walker;

   import ftsw_pkg::*;

   localparam int CB           = 12;
   localparam int FB           = 16;
   localparam int CSPAN        = 1 << CB;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int TAIL_CYCLES  = 200;
   localparam longint FIX_ONE  = longint'(1) << FB;

   typedef struct packed {
      logic                  op;
      logic [CB-1:0]         ax, ay, bx, by_c, cx, cy;
      logic [COLOR_BITS-1:0] color;
   } tri_item_type;

   typedef struct packed {
      logic [CB-1:0]         row;
      logic [CB:0]           left;
      logic [CB:0]           right;
      logic [COLOR_BITS-1:0] color;
      logic                  valid;
      logic                  last;
   } span_rsp_type;

   typedef struct {
      tri_item_type item;
      bit           typed;
      span_rsp_type want;
   } dir_row_type;

   logic                  clock;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_op         = OP_LOAD;
   logic [CB-1:0]         req_ax         = '0;
   logic [CB-1:0]         req_ay         = '0;
   logic [CB-1:0]         req_bx         = '0;
   logic [CB-1:0]         req_by_coord   = '0;
   logic [CB-1:0]         req_cx         = '0;
   logic [CB-1:0]         req_cy         = '0;
   logic [COLOR_BITS-1:0] req_fill_color = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [CB-1:0]         rsp_span_row;
   logic [CB:0]           rsp_span_left;
   logic [CB:0]           rsp_span_right;
   logic [COLOR_BITS-1:0] rsp_span_color;
   logic                  rsp_span_valid;
   logic                  rsp_span_last;

   // typed expectation travels with the item it belongs to
   bit           chk_typed = 1'b0;
   span_rsp_type chk_want  = '0;
   bit           calm      = 1'b0;

   span_rsp_type span_expect_q[$];
   dir_row_type  dir_q[$];
   int        err_cnt    = 0;
   int        cycle_cnt  = 0;
   int        items_sent = 0;
   int        rsp_hold   = 0;

   // span walker shadow state
   longint    vtx_x[3];
   longint    vtx_y[3];
   longint    split_at;
   longint    cur_row;
   longint    acc_a, acc_b;
   longint    step_a, step_b;
   phase_type walk_state;
   logic [COLOR_BITS-1:0] tri_color;

   flat_triangle_span_walker #(
      .COORD_BITS(CB),
      .FRAC_BITS (FB)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_ax        (req_ax),
      .req_ay        (req_ay),
      .req_bx        (req_bx),
      .req_by_coord  (req_by_coord),
      .req_cx        (req_cx),
      .req_cy        (req_cy),
      .req_fill_color(req_fill_color),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_span_row  (rsp_span_row),
      .rsp_span_left (rsp_span_left),
      .rsp_span_right(rsp_span_right),
      .rsp_span_color(rsp_span_color),
      .rsp_span_valid(rsp_span_valid),
      .rsp_span_last (rsp_span_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sx(input logic [CB-1:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint fixed_slope(input longint dx, input longint dy);
      if (dy == 0) return 0;
      return (dx * FIX_ONE) / dy;
   endfunction

   function automatic void order_vertices(input int i, input int j);
      longint t;
      if (vtx_y[i] > vtx_y[j]) begin
         t = vtx_y[i]; vtx_y[i] = vtx_y[j]; vtx_y[j] = t;
         t = vtx_x[i]; vtx_x[i] = vtx_x[j]; vtx_x[j] = t;
      end
   endfunction

   // flat-top part starts at the bottom vertex and climbs to the middle row
   function automatic void enter_upper_walk();
      longint dy;
      dy = vtx_y[2] - vtx_y[1];
      walk_state = PH_TOP;
      cur_row = vtx_y[2];
      acc_a = vtx_x[2] * FIX_ONE;
      acc_b = vtx_x[2] * FIX_ONE;
      step_a = fixed_slope(vtx_x[2] - vtx_x[1], dy);
      step_b = fixed_slope(vtx_x[2] - split_at, dy);
   endfunction

   function automatic bit walk_predict(input tri_item_type it, output span_rsp_type res);
      longint row, lx, rx, tmp;
      bit     last;
      res = '0;
      last = 1'b0;
      if (it.op == OP_LOAD) begin
         vtx_x[0] = sx(it.ax); vtx_y[0] = sx(it.ay);
         vtx_x[1] = sx(it.bx); vtx_y[1] = sx(it.by_c);
         vtx_x[2] = sx(it.cx); vtx_y[2] = sx(it.cy);
         tri_color = it.color;
         order_vertices(0, 1);
         order_vertices(1, 2);
         order_vertices(0, 1);
         if (vtx_y[2] == vtx_y[0])
            split_at = vtx_x[2];
         else
            split_at = vtx_x[0] + ((vtx_x[2] - vtx_x[0]) * (vtx_y[1] - vtx_y[0]))
                       / (vtx_y[2] - vtx_y[0]);
         if (vtx_y[0] == vtx_y[1] && vtx_y[1] != vtx_y[2]) begin
            enter_upper_walk();
         end else begin
            walk_state = PH_BOTTOM;
            cur_row = vtx_y[0];
            acc_a = vtx_x[0] * FIX_ONE;
            acc_b = vtx_x[0] * FIX_ONE;
            step_a = fixed_slope(vtx_x[1] - vtx_x[0], vtx_y[1] - vtx_y[0]);
            step_b = fixed_slope(split_at - vtx_x[0], vtx_y[1] - vtx_y[0]);
         end
         return 1'b0;
      end
      if (walk_state != PH_BOTTOM && walk_state != PH_TOP) return 1'b1;

      row = cur_row;
      lx = acc_a / FIX_ONE;
      rx = acc_b / FIX_ONE;
      if (rx < lx) begin
         tmp = lx; lx = rx; rx = tmp;
      end
      if (walk_state == PH_BOTTOM) begin
         if (row >= vtx_y[1]) begin
            if (vtx_y[1] == vtx_y[2]) begin
               last = 1'b1;
               walk_state = PH_IDLE;
            end else begin
               enter_upper_walk();
            end
         end else begin
            cur_row = row + 1;
            acc_a += step_a;
            acc_b += step_b;
         end
      end else begin
         if (row <= vtx_y[1]) begin
            last = 1'b1;
            walk_state = PH_IDLE;
         end else begin
            cur_row = row - 1;
            acc_a -= step_a;
            acc_b -= step_b;
         end
      end
      res.row   = row[CB-1:0];
      res.left  = lx[CB:0];
      res.right = rx[CB:0];
      res.color = tri_color;
      res.valid = 1'b1;
      res.last  = last;
      return 1'b1;
   endfunction

   // requests needed to walk a fresh triangle to its last span
   function automatic int span_rows(input tri_item_type t);
      longint a, b, c, lo, hi, md;
      a = sx(t.ay); b = sx(t.by_c); c = sx(t.cy);
      lo = (a < b) ? ((a < c) ? a : c) : ((b < c) ? b : c);
      hi = (a > b) ? ((a > c) ? a : c) : ((b > c) ? b : c);
      md = a + b + c - lo - hi;
      if (lo == hi) return 1;
      if (lo == md || md == hi) return int'(hi - lo + 1);
      return int'(hi - lo + 2);
   endfunction

   function automatic int pick_gap(input int idle_pct);
      if (calm || $urandom_range(0, 99) >= idle_pct) return 0;
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic tri_item_type rand_item();
      tri_item_type t;
      t.op    = 1'($urandom_range(0, 1));
      t.ax    = CB'($urandom_range(0, CSPAN - 1));
      t.ay    = CB'($urandom_range(0, CSPAN - 1));
      t.bx    = CB'($urandom_range(0, CSPAN - 1));
      t.by_c  = CB'($urandom_range(0, CSPAN - 1));
      t.cx    = CB'($urandom_range(0, CSPAN - 1));
      t.cy    = CB'($urandom_range(0, CSPAN - 1));
      t.color = $urandom;
      return t;
   endfunction

   function automatic tri_item_type span_request();
      tri_item_type t;
      t = rand_item();
      t.op = OP_SPAN;
      return t;
   endfunction

   // mostly short triangles anywhere in y, now and then a taller one
   function automatic tri_item_type rand_triangle();
      tri_item_type t;
      int h, base;
      t = rand_item();
      t.op = OP_LOAD;
      h = ($urandom_range(0, 99) < 6) ? $urandom_range(20, 250) : $urandom_range(0, 10);
      base = $urandom_range(0, CSPAN - 1 - h) - CSPAN / 2;
      t.ay   = CB'(base + $urandom_range(0, h));
      t.by_c = CB'(base + $urandom_range(0, h));
      t.cy   = CB'(base + $urandom_range(0, h));
      return t;
   endfunction

   function automatic void dir_load(input int ax, input int ay, input int bx, input int by_c,
                                    input int cx, input int cy, input logic [31:0] color);
      dir_row_type d;
      d.item = {OP_LOAD, CB'(ax), CB'(ay), CB'(bx), CB'(by_c), CB'(cx), CB'(cy), color};
      d.typed = 1'b0;
      d.want = '0;
      dir_q.push_back(d);
   endfunction

   function automatic void dir_span();
      dir_row_type d;
      d.item = '0;
      d.item.op = OP_SPAN;
      d.typed = 1'b0;
      d.want = '0;
      dir_q.push_back(d);
   endfunction

   function automatic void dir_span_typed(input logic valid, input int row, input int left,
                                          input int right, input logic [31:0] color,
                                          input logic last);
      dir_row_type d;
      d.item = '0;
      d.item.op = OP_SPAN;
      d.typed = 1'b1;
      d.want = {CB'(row), (CB+1)'(left), (CB+1)'(right), color, valid, last};
      dir_q.push_back(d);
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      err_cnt++;
      if (err_cnt <= 40)
         $display("cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
   endtask

   task automatic send_item(input tri_item_type it, input bit typed, input span_rsp_type want);
      int gap;
      gap = pick_gap(40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= it.op;
      req_ax         <= it.ax;
      req_ay         <= it.ay;
      req_bx         <= it.bx;
      req_by_coord   <= it.by_c;
      req_cx         <= it.cx;
      req_cy         <= it.cy;
      req_fill_color <= it.color;
      chk_typed      <= typed;
      chk_want       <= want;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // predict on acceptance and check results in one process, so ordering is fixed
   always @(posedge clock) begin
      tri_item_type taken;
      span_rsp_type fresh, want;
      int n;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("** flat_triangle_span_walker: FAILED **");
         $finish;
      end else if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vtx_x[i] = 0;
            vtx_y[i] = 0;
         end
         split_at = 0; cur_row = 0;
         acc_a = 0; acc_b = 0; step_a = 0; step_b = 0;
         walk_state = PH_IDLE;
         tri_color = '0;
         span_expect_q.delete();
         rsp_hold = 0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken = {req_op, req_ax, req_ay, req_bx, req_by_coord, req_cx, req_cy,
                     req_fill_color};
            if (walk_predict(taken, fresh))
               span_expect_q.push_back(chk_typed ? chk_want : fresh);
         end
         if (rsp_valid && rsp_ready) begin
            if (span_expect_q.size() == 0) begin
               flag_mismatch("item with nothing expected, row", rsp_span_row, 0);
            end else begin
               want = span_expect_q.pop_front();
               if (rsp_span_valid !== want.valid)
                  flag_mismatch("span_valid", rsp_span_valid, want.valid);
               if (rsp_span_row !== want.row)
                  flag_mismatch("span_row", rsp_span_row, want.row);
               if (rsp_span_left !== want.left)
                  flag_mismatch("span_left", rsp_span_left, want.left);
               if (rsp_span_right !== want.right)
                  flag_mismatch("span_right", rsp_span_right, want.right);
               if (rsp_span_color !== want.color)
                  flag_mismatch("span_color", rsp_span_color, want.color);
               if (rsp_span_last !== want.last)
                  flag_mismatch("span_last", rsp_span_last, want.last);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            n = pick_gap(20);
            if (n > 0) begin
               rsp_hold = n - 1;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   initial begin
      tri_item_type t;
      int n, r;

      // idle after reset
      dir_span_typed(1'b0, 0, 0, 0, 32'h0, 1'b0);
      // all three rows equal, ties keep input order
      dir_load(5, 7, -3, 7, 100, 7, 32'hDEADBEEF);
      dir_span_typed(1'b1, 7, 5, 5, 32'hDEADBEEF, 1'b1);
      dir_span_typed(1'b0, 0, 0, 0, 32'h0, 1'b0);
      // flat top edge at the lowest rows, widest span
      dir_load(-2048, -2048, 2047, -2048, 0, -2046, 32'hFFFFFFFF);
      repeat (3) dir_span();
      // flat bottom edge at the highest rows
      dir_load(0, 2045, -2048, 2047, 2047, 2047, 32'h0);
      repeat (3) dir_span();
      // general triangle abandoned by a new load
      dir_load(10, 0, -20, 3, 30, 5, 32'h12345678);
      repeat (2) dir_span();
      dir_load(-2048, 2047, 2047, 2047, 0, 2047, 32'h1);
      dir_span_typed(1'b1, 2047, -2048, -2048, 32'h1, 1'b1);
      // same triangle, vertices rotated, walked to the end: middle row twice
      dir_load(30, 5, 10, 0, -20, 3, 32'hA5A5A5A5);
      repeat (7) dir_span();
      dir_span_typed(1'b0, 0, 0, 0, 32'h0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_q[i]) send_item(dir_q[i].item, dir_q[i].typed, dir_q[i].want);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         calm <= ($urandom_range(0, 99) < 15);
         r = $urandom_range(0, 99);
         if (r < 70) begin
            t = rand_triangle();
            n = span_rows(t);
            send_item(t, 1'b0, '0);
            repeat (n) send_item(span_request(), 1'b0, '0);
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 2)) send_item(span_request(), 1'b0, '0);
         end else if (r < 85) begin
            send_item(rand_triangle(), 1'b0, '0);
            repeat ($urandom_range(0, 5)) send_item(span_request(), 1'b0, '0);
         end else begin
            repeat ($urandom_range(1, 4)) send_item(rand_item(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (span_expect_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("** flat_triangle_span_walker: PASSED **");
      else
         $display("** flat_triangle_span_walker: FAILED **");
      $finish;
   end

endmodule
